// ===== hdl/lprs_pkg.sv =====
// lprs_pkg: shared types and constants for the LED panel row-scan block.
// Used by lprs_ctrl, lprs_dp and led_panel_row_scan. No dependencies.
package lprs_pkg;

  localparam int STORE_AW    = 7;
  localparam int STORE_DEPTH = 128;
  localparam int BYTE_W      = 8;
  localparam int ROWB_W      = 4;
  localparam int ROWS_W      = 5;
  localparam int ROW_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;

  localparam logic [BYTE_W-1:0] INVERT_MASK = 8'hFF;

  localparam logic [ROWB_W-1:0] ROW_BYTES_RST = 4'd4;
  localparam logic [ROWS_W-1:0] ROWS_RST      = 5'd16;
  localparam logic              INVERT_RST    = 1'b1;
  localparam logic              ENABLE_RST    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd3;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_SCAN  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } lprs_state_t;

  typedef struct packed {
    logic wr;
    logic load;
    logic step;
  } lprs_cmd_t;

  typedef struct packed {
    logic enable;
    logic last_col;
  } lprs_sts_t;

endpackage

// ===== hdl/lprs_ctrl.sv =====
// lprs_ctrl: scan controller state machine for the LED panel row-scan block.
// Depends on lprs_pkg; drives commands into lprs_dp.
module lprs_ctrl
  import lprs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_func,
  input  lprs_sts_t sts,
  output lprs_cmd_t cmd,
  output logic      busy
);

  lprs_state_t state_r;
  lprs_state_t state_nxt;
  logic        idle_go;

  assign idle_go = (state_r == ST_IDLE) && start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && (in_func == FUNC_SCAN) && sts.enable) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.last_col) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.wr   = idle_go && (in_func == FUNC_WRITE);
        cmd.load = idle_go && (in_func == FUNC_SCAN) && sts.enable;
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        busy     = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/lprs_dp.sv =====
// lprs_dp: datapath of the LED panel row-scan block: config registers,
// frame store with valid bits, scan row, column counter and output stage. Uses lprs_pkg.
module lprs_dp
  import lprs_pkg::*;
#(
  parameter int MAX_ROW_BYTES = 8,
  parameter int MAX_ROWS      = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lprs_cmd_t             cmd,
  output lprs_sts_t             sts,
  input  logic [STORE_AW-1:0]   in_address,
  input  logic [BYTE_W-1:0]     in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic [BYTE_W-1:0]     out_pixel_byte,
  output logic [ROW_W-1:0]      out_row_address,
  output logic                  out_latch
);

  localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

  logic [ROWB_W-1:0]   row_bytes_r;
  logic [ROWS_W-1:0]   rows_r;
  logic                invert_r;
  logic                enable_r;

  logic [ROW_W-1:0]    scan_row_r;
  logic [ROW_W-1:0]    scan_row_nxt;
  logic [STORE_AW-1:0] base_r;
  logic [COL_W-1:0]    col_r;
  logic [ROW_W-1:0]    row_addr_r;
  logic [BYTE_W-1:0]   xor_r;

  logic [ROWB_W-1:0]   nbytes;
  logic [ROWS_W-1:0]   nrows;
  logic [STORE_AW-1:0] rd_addr;

  logic [BYTE_W-1:0]   mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_r;
  logic [BYTE_W-1:0]   rd_q_r;
  logic                rd_hit_r;
  logic                out_vld_r;
  logic                out_last_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= ROW_BYTES_RST;
      rows_r      <= ROWS_RST;
      invert_r    <= INVERT_RST;
      enable_r    <= ENABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_BYTES: row_bytes_r <= cfg_data[ROWB_W-1:0];
        REG_ROWS:      rows_r      <= cfg_data[ROWS_W-1:0];
        REG_INVERT:    invert_r    <= cfg_data[0];
        REG_ENABLE:    enable_r    <= cfg_data[0];
        default:       enable_r    <= enable_r;
      endcase
    end
  end

  always_comb begin
    if (row_bytes_r == '0) begin
      nbytes = ROWB_W'(1);
    end else if (row_bytes_r > ROWB_W'(MAX_ROW_BYTES)) begin
      nbytes = ROWB_W'(MAX_ROW_BYTES);
    end else begin
      nbytes = row_bytes_r;
    end
    if (rows_r == '0) begin
      nrows = ROWS_W'(1);
    end else if (rows_r > ROWS_W'(MAX_ROWS)) begin
      nrows = ROWS_W'(MAX_ROWS);
    end else begin
      nrows = rows_r;
    end
    if (({1'b0, scan_row_r} + ROWS_W'(1)) >= nrows) begin
      scan_row_nxt = '0;
    end else begin
      scan_row_nxt = scan_row_r + ROW_W'(1);
    end
  end

  // latch the row setup on a scan, then count columns down
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_row_r <= '0;
    end else if (cmd.load) begin
      scan_row_r <= scan_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r     <= STORE_AW'(scan_row_r) * STORE_AW'(nbytes);
      col_r      <= COL_W'(nbytes - ROWB_W'(1));
      row_addr_r <= ROW_W'(nrows - ROWS_W'(1) - {1'b0, scan_row_r});
      xor_r      <= invert_r ? INVERT_MASK : '0;
    end else if (cmd.step) begin
      col_r <= col_r - COL_W'(1);
    end
  end

  assign rd_addr = base_r + STORE_AW'(col_r);

  // frame store
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[in_address] <= in_data;
    end
    if (cmd.step) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.wr) begin
      vld_r[in_address] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rd_hit_r   <= vld_r[rd_addr];
      out_last_r <= (col_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= cmd.step;
    end
  end

  assign sts.enable   = enable_r;
  assign sts.last_col = (col_r == '0);

  assign out_valid       = out_vld_r;
  assign out_pixel_byte  = (rd_hit_r ? rd_q_r : '0) ^ xor_r;
  assign out_row_address = row_addr_r;
  assign out_latch       = out_vld_r && out_last_r;

endmodule

// ===== hdl/led_panel_row_scan.sv =====
// led_panel_row_scan: top level of the LED panel row-scan block.
// Instantiates lprs_ctrl and lprs_dp; uses lprs_pkg.
//
// Usage:
//   Input: present in_func/in_address/in_data with start; the word is taken
//   at a clock edge with start high and busy low. A write word (in_func 0)
//   stores one byte into the frame store in that cycle and never raises busy.
//   A scan word (in_func 1) with the display enabled raises busy while it
//   reads a row of row_bytes bytes, clamped to 1..MAX_ROW_BYTES; with the
//   display disabled it is dropped and busy stays low.
//   Output: each pixel byte shows for one cycle with out_valid high, last
//   column first, one per cycle, after the row setup and the first store read
//   are registered. out_latch marks the last byte of the row. The receiver
//   cannot stall. A scan word waits for busy to drop (single frame store
//   read port, one byte per cycle); writes go each cycle that busy is low.
//   Config: cfg_we/cfg_index/cfg_data write a register; write only while
//   busy is low and no byte is pending.
//   Reset: registers take their defaults, the scan row returns to 0 and the
//   frame store reads as zero at once (per-entry valid bits, no clear pass).
module led_panel_row_scan
  import lprs_pkg::*;
#(
  parameter int MAX_ROW_BYTES = 8,
  parameter int MAX_ROWS      = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_func,
  input  logic [STORE_AW-1:0]   in_address,
  input  logic [BYTE_W-1:0]     in_data,
  output logic                  out_valid,
  output logic [BYTE_W-1:0]     out_pixel_byte,
  output logic [ROW_W-1:0]      out_row_address,
  output logic                  out_latch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  lprs_cmd_t cmd;
  lprs_sts_t sts;

  lprs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  lprs_dp #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .MAX_ROWS      (MAX_ROWS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_address      (in_address),
    .in_data         (in_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_pixel_byte  (out_pixel_byte),
    .out_row_address (out_row_address),
    .out_latch       (out_latch)
  );

  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("output byte without a scan in progress");

  a_busy_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && (in_func == FUNC_SCAN)))
    else $error("busy raised without a scan word");

  a_latch_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_latch) |-> !busy)
    else $error("row latched while scan still running");

  a_busy_streams: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("scan cycle produced no byte");

endmodule
